// ===== design/bdsi_pkg.sv =====
// Package for the bounded deque with sorted insert: sizes, codes and payload types.
package bdsi_pkg;

    localparam int DEPTH       = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);

    localparam int LIMIT_W     = 5;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 5;

    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_POP  = 2'd1;
    localparam logic [1:0] OP_PEEK = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_CAPACITY_LIMIT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SORTED_MODE    = 2'd1;

    typedef struct packed {
        logic [1:0]  op;
        logic        front_end;
        logic [31:0] value;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] data_out;
        logic [4:0]  old_count;
        logic [4:0]  count;
    } out_item_t;

    // shared command seen by every cell in one cycle
    typedef struct packed {
        logic                   push_front;
        logic                   push_back;
        logic                   push_sorted;
        logic                   pop_front;
        logic [VALUE_WIDTH-1:0] value;
    } cell_cmd_t;

endpackage

// ===== design/bounded_deque_sorted_insert.sv =====
// Top level of the bounded deque with sorted insert: cell row, count, config and result register.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+----------------------------
//  command | in        | start & !busy           | cmd (in_item_t)
//  result  | out       | done, one cycle         | result (out_item_t)
//  config  | in        | cfg_valid & cfg_ready   | cfg_index, cfg_data
//
// One operation per cycle; the result shows on the cycle after the transfer.
// All positions update in parallel in the cell row, including sorted inserts.
// busy is held low; reset clears count, config registers and done, stored values
// and the result register are left as they are. The receiver cannot stall the result.
module bounded_deque_sorted_insert
    import bdsi_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  in_item_t               cmd,
    output logic                   done,
    output out_item_t              result,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [CNT_W-1:0]       count_reg, count_next;
    logic [LIMIT_W-1:0]     limit_reg;
    logic                   sorted_reg;
    logic                   done_reg;
    out_item_t              result_reg, result_next;

    logic [CNT_W-1:0]       eff_limit;
    logic [CNT_W-1:0]       tail_pos;
    logic                   accept;
    logic                   is_full;
    logic                   is_empty;
    cell_cmd_t              cell_cmd;
    logic [VALUE_WIDTH-1:0] cell_val [DEPTH];
    logic [DEPTH:0]         chain;
    logic [VALUE_WIDTH-1:0] back_value;
    logic [VALUE_WIDTH-1:0] end_value;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    always_comb
    begin
        if (limit_reg == '0 || 32'(limit_reg) > DEPTH)
        begin
            eff_limit = CNT_W'(DEPTH);
        end
        else
        begin
            eff_limit = CNT_W'(limit_reg);
        end
    end

    assign is_full  = count_reg >= eff_limit;
    assign is_empty = count_reg == '0;
    assign tail_pos = count_reg - CNT_W'(1);

    always_comb
    begin
        cell_cmd             = '0;
        cell_cmd.value       = cmd.value[VALUE_WIDTH-1:0];
        if (accept && cmd.op == OP_PUSH && !is_full)
        begin
            cell_cmd.push_sorted = sorted_reg;
            cell_cmd.push_front  = !sorted_reg && cmd.front_end;
            cell_cmd.push_back   = !sorted_reg && !cmd.front_end;
        end
        if (accept && cmd.op == OP_POP && !is_empty)
        begin
            cell_cmd.pop_front = cmd.front_end;
        end
    end

    assign chain[0] = 1'b1;

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            logic [VALUE_WIDTH-1:0] left_v;
            logic [VALUE_WIDTH-1:0] right_v;
            if (i == 0)
            begin : g_first
                assign left_v = cell_cmd.value;
            end
            else
            begin : g_mid
                assign left_v = cell_val[i-1];
            end
            if (i == DEPTH - 1)
            begin : g_last
                assign right_v = cell_val[i];
            end
            else
            begin : g_inner
                assign right_v = cell_val[i+1];
            end

            bdsi_cell u_cell (
                .clk         (clk),
                .cmd         (cell_cmd),
                .occupied    (CNT_W'(i) < count_reg),
                .at_tail     (CNT_W'(i) == count_reg),
                .left_value  (left_v),
                .right_value (right_v),
                .chain_in    (chain[i]),
                .chain_out   (chain[i+1]),
                .value_q     (cell_val[i])
            );
        end
    endgenerate

    assign back_value = cell_val[tail_pos[IDX_W-1:0]];
    assign end_value  = cmd.front_end ? cell_val[0] : back_value;

    always_comb
    begin
        count_next  = count_reg;
        result_next = '0;
        case (cmd.op)
            OP_PUSH:
            begin
                if (is_full)
                begin
                    result_next.status = ST_FULL;
                end
                else
                begin
                    result_next.old_count = 5'(count_reg);
                    count_next            = count_reg + CNT_W'(1);
                end
            end
            OP_POP:
            begin
                if (is_empty)
                begin
                    result_next.status = ST_EMPTY;
                end
                else
                begin
                    result_next.data_out = 32'(end_value);
                    count_next           = tail_pos;
                end
            end
            OP_PEEK:
            begin
                if (is_empty)
                begin
                    result_next.status = ST_EMPTY;
                end
                else
                begin
                    result_next.data_out = 32'(end_value);
                end
            end
            default:
            begin
                result_next.status = ST_OK;
            end
        endcase
        result_next.count = 5'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            limit_reg  <= '0;
            sorted_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= accept;
            if (accept)
            begin
                count_reg <= count_next;
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_CAPACITY_LIMIT)
                begin
                    limit_reg <= cfg_data[LIMIT_W-1:0];
                end
                else if (cfg_index == REG_SORTED_MODE)
                begin
                    sorted_reg <= cfg_data[0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== design/bdsi_cell.sv =====
// One deque position: holds a value and shifts, loads or inserts per the shared command.
module bdsi_cell
    import bdsi_pkg::*;
(
    input  logic                   clk,
    input  cell_cmd_t              cmd,
    input  logic                   occupied,
    input  logic                   at_tail,
    input  logic [VALUE_WIDTH-1:0] left_value,
    input  logic [VALUE_WIDTH-1:0] right_value,
    input  logic                   chain_in,
    output logic                   chain_out,
    output logic [VALUE_WIDTH-1:0] value_q
);

    logic [VALUE_WIDTH-1:0] value_reg;
    logic [VALUE_WIDTH-1:0] value_next;
    logic                   lt;

    // this cell and all cells to its left hold values smaller than the command value
    assign lt        = occupied && (value_reg < cmd.value);
    assign chain_out = chain_in && lt;

    always_comb
    begin
        value_next = value_reg;
        if (cmd.push_front)
        begin
            value_next = left_value;
        end
        else if (cmd.push_back)
        begin
            if (at_tail)
            begin
                value_next = cmd.value;
            end
        end
        else if (cmd.push_sorted)
        begin
            if (chain_in && !lt)
            begin
                value_next = cmd.value;
            end
            else if (!chain_in)
            begin
                value_next = left_value;
            end
        end
        else if (cmd.pop_front)
        begin
            value_next = right_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value_q = value_reg;

endmodule
